// ===== design/pse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_pkg
// Shared constants, types and the control store of the postfix evaluator.
// ----------------------------------------------------------------------------
package pse_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 16;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Divider: one quotient bit per cycle
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  // Character codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;

  // Result error codes
  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_UNDERFLOW = 2'd1,
    ERR_FULL      = 2'd2,
    ERR_DIVZERO   = 2'd3
  } err_t;

  // Microprogram addresses
  localparam int STEP_W = 4;
  typedef enum logic [STEP_W-1:0] {
    S_FETCH  = 4'd0,
    S_DECODE = 4'd1,
    S_PUSH   = 4'd2,
    S_RDB    = 4'd3,
    S_RDA    = 4'd4,
    S_LATA   = 4'd5,
    S_ALU    = 4'd6,
    S_DIVGO  = 4'd7,
    S_DIVW   = 4'd8,
    S_WRQ    = 4'd9,
    S_ERRUF  = 4'd10,
    S_ERRFL  = 4'd11,
    S_ERRDZ  = 4'd12,
    S_END    = 4'd13,
    S_EMIT   = 4'd14
  } step_t;

  // Sequencer branch conditions
  typedef enum logic [2:0] {
    J_NEXT,      // fall through
    J_ALWAYS,    // go to target
    J_WAITIN,    // hold at target until an item is taken
    J_DECODE,    // dispatch on character class
    J_OPSEL,     // dispatch on operator and divisor
    J_DIVBUSY,   // hold at target while the divider runs
    J_LAST,      // last item: fall through, else go to target
    J_WAITOUT    // hold until the output slot frees, then go to target
  } jcond_t;

  typedef enum logic [1:0] {
    RD_NONE,
    RD_TOP,
    RD_SEC
  } rsel_t;

  typedef enum logic [1:0] {
    WS_NONE,
    WS_SYM,
    WS_ALU,
    WS_QUO
  } wsel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cntop_t;

  // One control word
  typedef struct packed {
    jcond_t jc;
    step_t  target;
    rsel_t  rd;
    logic   ld_b;
    logic   ld_a;
    logic   div_go;
    wsel_t  wsel;
    cntop_t cnt;
    err_t   set_err;
    logic   emit;
  } uword_t;

  // Control store
  function automatic uword_t ucode_rom(step_t addr);
    uword_t w;
    w         = '0;
    w.jc      = J_NEXT;
    w.target  = S_FETCH;
    w.rd      = RD_NONE;
    w.wsel    = WS_NONE;
    w.cnt     = CNT_HOLD;
    w.set_err = ERR_NONE;
    case (addr)
      S_FETCH:  begin w.jc = J_WAITIN; w.target = S_FETCH; end
      S_DECODE: begin w.jc = J_DECODE; end
      S_PUSH:   begin
        w.wsel = WS_SYM; w.cnt = CNT_INC; w.jc = J_ALWAYS; w.target = S_END;
      end
      S_RDB:    begin w.rd = RD_TOP; end
      S_RDA:    begin w.rd = RD_SEC; w.ld_b = 1'b1; end
      S_LATA:   begin w.ld_a = 1'b1; w.jc = J_OPSEL; end
      S_ALU:    begin
        w.wsel = WS_ALU; w.cnt = CNT_DEC; w.jc = J_ALWAYS; w.target = S_END;
      end
      S_DIVGO:  begin w.div_go = 1'b1; end
      S_DIVW:   begin w.jc = J_DIVBUSY; w.target = S_DIVW; end
      S_WRQ:    begin
        w.wsel = WS_QUO; w.cnt = CNT_DEC; w.jc = J_ALWAYS; w.target = S_END;
      end
      S_ERRUF:  begin w.set_err = ERR_UNDERFLOW; w.jc = J_ALWAYS; w.target = S_END; end
      S_ERRFL:  begin w.set_err = ERR_FULL; w.jc = J_ALWAYS; w.target = S_END; end
      S_ERRDZ:  begin w.set_err = ERR_DIVZERO; end
      S_END:    begin w.rd = RD_TOP; w.jc = J_LAST; w.target = S_FETCH; end
      S_EMIT:   begin w.emit = 1'b1; w.jc = J_WAITOUT; w.target = S_FETCH; end
      default:  begin w.jc = J_ALWAYS; w.target = S_FETCH; end
    endcase
    return w;
  endfunction

endpackage

// ===== design/pse_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/pse_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_div
// Iterative signed divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module pse_div
  import pse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              busy,
  output logic [DATA_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DATA_W-1:0]    quo_r, quo_nxt;
  logic [DATA_W-1:0]    den_r, den_nxt;
  logic                 neg_r, neg_nxt;
  logic [DATA_W:0]      shifted;
  logic [DATA_W:0]      diff;

  // one restoring step
  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
      den_nxt  = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
      neg_nxt  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_nxt = diff[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DATA_W-1:0];
        quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DATA_W - 1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

// ===== design/postfix_stack_evaluator.sv =====
`timescale 1ns / 1ps
// Items are handled one at a time by the single-stepping microcode sequencer
// and the single read port of the stack RAM; in_stall stays high until the
// item is done. A / waits on the bit-per-cycle divider; an item flagged last
// adds a step to load the result register, held while the output slot is full.
// Reset (synchronous, rst_n low) clears the sequencer, stack count, error
// and output valid; stack RAM contents are not cleared.
// ----------------------------------------------------------------------------
// postfix_stack_evaluator
// Microcoded postfix evaluator over a bounded stack of 32-bit values.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator
  import pse_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_symbol,
  input  logic              in_last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [31:0] out_value,
  output logic [1:0]        out_error_code
);

  step_t             upc_r, upc_nxt;
  uword_t            uw;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  err_t              err_r, err_nxt;
  logic [7:0]        sym_r;
  logic              last_r;
  logic [DATA_W-1:0] a_r, b_r;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_value_r;
  err_t              out_err_r;

  logic              in_acc;
  logic              out_free;
  logic              emit_fire;
  logic              is_blank, is_op;
  logic [CNT_W-1:0]  cnt_m1, cnt_m2;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;
  logic [DATA_W-1:0] alu_res;
  logic [DATA_W-1:0] quo;
  logic              div_busy;
  step_t             step_inc;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (upc_r != S_FETCH);
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_fire = uw.emit && out_free;
  assign cnt_m1    = cnt_r - 1'b1;
  assign cnt_m2    = cnt_r - 2'd2;
  assign step_inc  = step_t'(STEP_W'(upc_r + 1'b1));

  // character class
  assign is_blank = (sym_r == CH_SPACE) || (sym_r == CH_NEWLINE);
  assign is_op    = (sym_r == CH_PLUS) || (sym_r == CH_MINUS) ||
                    (sym_r == CH_STAR) || (sym_r == CH_SLASH);

  // control word for this step
  always_comb begin
    uw = ucode_rom(upc_r);
  end

  // sequencer next step
  always_comb begin
    upc_nxt = step_inc;
    case (uw.jc)
      J_NEXT:    upc_nxt = step_inc;
      J_ALWAYS:  upc_nxt = uw.target;
      J_WAITIN:  upc_nxt = in_acc ? step_inc : uw.target;
      J_DECODE: begin
        if (err_r != ERR_NONE || is_blank) begin
          upc_nxt = S_END;
        end else if (is_op) begin
          upc_nxt = (cnt_r < CNT_W'(2)) ? S_ERRUF : S_RDB;
        end else begin
          upc_nxt = (cnt_r >= CNT_W'(STACK_DEPTH)) ? S_ERRFL : S_PUSH;
        end
      end
      J_OPSEL: begin
        if (sym_r != CH_SLASH) begin
          upc_nxt = S_ALU;
        end else if (b_r == '0) begin
          upc_nxt = S_ERRDZ;
        end else begin
          upc_nxt = S_DIVGO;
        end
      end
      J_DIVBUSY: upc_nxt = div_busy ? uw.target : step_inc;
      J_LAST:    upc_nxt = last_r ? step_inc : uw.target;
      J_WAITOUT: upc_nxt = out_free ? uw.target : upc_r;
      default:   upc_nxt = S_FETCH;
    endcase
  end

  // datapath controls
  always_comb begin
    ram_re    = (uw.rd != RD_NONE);
    ram_raddr = (uw.rd == RD_SEC) ? cnt_m2[ADDR_W-1:0] : cnt_m1[ADDR_W-1:0];
    ram_we    = (uw.wsel != WS_NONE);
    ram_waddr = (uw.wsel == WS_SYM) ? cnt_r[ADDR_W-1:0] : cnt_m2[ADDR_W-1:0];
    case (uw.wsel)
      WS_SYM:  ram_wdata = {{(DATA_W-8){1'b0}}, sym_r} - DATA_W'(CH_ZERO);
      WS_ALU:  ram_wdata = alu_res;
      WS_QUO:  ram_wdata = quo;
      default: ram_wdata = alu_res;
    endcase
  end

  // add, subtract, multiply (low word)
  always_comb begin
    case (sym_r)
      CH_PLUS:  alu_res = a_r + b_r;
      CH_MINUS: alu_res = a_r - b_r;
      default:  alu_res = DATA_W'(a_r * b_r);
    endcase
  end

  // count, error latch and output slot
  always_comb begin
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (uw.cnt)
      CNT_INC:  cnt_nxt = cnt_r + 1'b1;
      CNT_DEC:  cnt_nxt = cnt_m1;
      default:  cnt_nxt = cnt_r;
    endcase
    if (uw.set_err != ERR_NONE) begin
      err_nxt = uw.set_err;
    end
    if (emit_fire) begin
      cnt_nxt       = '0;
      err_nxt       = ERR_NONE;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= S_FETCH;
      cnt_r       <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sym_r  <= in_symbol;
      last_r <= in_last;
    end
    if (uw.ld_b) begin
      b_r <= ram_rdata;
    end
    if (uw.ld_a) begin
      a_r <= ram_rdata;
    end
    if (emit_fire) begin
      if (err_r != ERR_NONE) begin
        out_err_r   <= err_r;
        out_value_r <= '0;
      end else if (cnt_r == '0) begin
        out_err_r   <= ERR_UNDERFLOW;
        out_value_r <= '0;
      end else begin
        out_err_r   <= ERR_NONE;
        out_value_r <= ram_rdata;
      end
    end
  end

  pse_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pse_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (uw.div_go),
    .dividend (a_r),
    .divisor  (b_r),
    .busy     (div_busy),
    .quotient (quo)
  );

  assign out_valid      = out_valid_r;
  assign out_value      = out_value_r;
  assign out_error_code = out_err_r;

endmodule

// ===== design/pse_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pse_checker
// Port-level checks for the postfix evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module pse_checker
  import pse_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic signed [31:0] out_value,
  input logic [1:0]        out_error_code
);

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_value) &&
                               $stable(out_error_code))
    else $error("stalled result item changed");

  // an error result carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != ERR_NONE) |-> (out_value == 0))
    else $error("error result with nonzero value");

  // reset empties the output slot
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one item at a time: the block is busy right after taking an item
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while previous item in work");

endmodule

bind postfix_stack_evaluator pse_checker u_pse_checker (.*);

// ===== bench/tb_postfix_stack_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_postfix_stack_evaluator
// Feeds postfix expressions one character per item: a short table of
// hand-picked cases, then random well-formed, damaged and noise expressions.
// A stack calculator in the bench predicts each expression's value and error
// code. Results are checked in order; idling is random until the last third.
// ----------------------------------------------------------------------------
module tb_postfix_stack_evaluator
  import pse_pkg::*;
();

  localparam int RANDOM_ITEMS = 1950;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 10;
  localparam int DIR_ROWS     = 23;

  // Operand characters used by the table
  localparam logic [7:0] SYM_128   = 8'd176;   // pushes 128
  localparam logic [7:0] SYM_EIGHT = 8'h38;
  localparam logic [7:0] SYM_ONE   = 8'h31;

  typedef struct packed {
    logic signed [31:0] value;
    err_t               code;
  } eval_result_t;

  typedef struct packed {
    logic [7:0]         sym;
    logic               lst;
    logic               typed;   // expected result written in the row
    logic signed [31:0] value;
    err_t               code;
  } dir_row_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [7:0]         in_symbol = 8'd0;
  logic               in_last   = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_value;
  logic [1:0]         out_error_code;

  // Bench copy of the operand stack
  logic [31:0] calc_stack [STACK_DEPTH];
  int          calc_depth = 0;
  err_t        calc_err   = ERR_NONE;

  eval_result_t expected_q [$];
  logic [7:0]   expr_syms [$];

  int fail_count       = 0;
  int checked_count    = 0;
  int err_result_count = 0;
  int item_count       = 0;
  int expr_count       = 0;
  int send_idle_pct    = 0;
  int recv_stall_pct   = 0;
  int quiet_cycles     = 0;

  // Directed cases, one character per row
  dir_row_t dir_rows [DIR_ROWS] = '{
    // operator on an empty stack
    '{CH_PLUS,    1'b1, 1'b1, 32'sd0, ERR_UNDERFLOW},
    // nothing but a blank: empty stack at the end
    '{CH_SPACE,   1'b1, 1'b1, 32'sd0, ERR_UNDERFLOW},
    // lowest and highest codes, newline skipped
    '{8'h00,      1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{CH_NEWLINE, 1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{8'hFF,      1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{CH_PLUS,    1'b1, 1'b0, 32'sd0, ERR_NONE},
    // divide by zero, then a character that must be ignored
    '{CH_ZERO,    1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{CH_ZERO,    1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{CH_SLASH,   1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{CH_PLUS,    1'b1, 1'b1, 32'sd0, ERR_DIVZERO},
    // 128^4 * 8 wraps to the most negative value, then divided by -1
    '{SYM_128,    1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{SYM_128,    1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{CH_STAR,    1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{SYM_128,    1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{CH_STAR,    1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{SYM_128,    1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{CH_STAR,    1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{SYM_EIGHT,  1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{CH_STAR,    1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{CH_ZERO,    1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{SYM_ONE,    1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{CH_MINUS,   1'b0, 1'b0, 32'sd0, ERR_NONE},
    '{CH_SLASH,   1'b1, 1'b1, 32'h8000_0000, ERR_NONE}
  };

  postfix_stack_evaluator u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_symbol      (in_symbol),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_error_code (out_error_code)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic bit is_operator(input logic [7:0] sym);
    return sym == CH_PLUS || sym == CH_MINUS || sym == CH_STAR || sym == CH_SLASH;
  endfunction

  function automatic bit is_blank(input logic [7:0] sym);
    return sym == CH_SPACE || sym == CH_NEWLINE;
  endfunction

  // Stack calculator: advances on one character, returns 1 with the result
  // when the character closes the expression
  function automatic bit eval_symbol(input logic [7:0] sym, input logic lst,
                                     output eval_result_t res);
    logic [31:0] a;
    logic [31:0] b;
    longint      sa;
    longint      sb;
    res       = '0;
    res.code  = ERR_NONE;
    if (calc_err == ERR_NONE && !is_blank(sym)) begin
      if (is_operator(sym)) begin
        if (calc_depth < 2) begin
          calc_err = ERR_UNDERFLOW;
        end else begin
          b = calc_stack[calc_depth-1];
          a = calc_stack[calc_depth-2];
          if (sym == CH_SLASH && b == 32'd0) begin
            calc_err = ERR_DIVZERO;
          end else begin
            case (sym)
              CH_PLUS:  a = a + b;
              CH_MINUS: a = a - b;
              CH_STAR:  a = a * b;
              default: begin
                // 64-bit quotient so that min / -1 wraps cleanly
                sa = $signed(a);
                sb = $signed(b);
                a  = 32'(sa / sb);
              end
            endcase
            calc_stack[calc_depth-2] = a;
            calc_depth--;
          end
        end
      end else if (calc_depth >= STACK_DEPTH) begin
        calc_err = ERR_FULL;
      end else begin
        calc_stack[calc_depth] = {24'd0, sym} - {24'd0, CH_ZERO};
        calc_depth++;
      end
    end
    if (!lst) return 1'b0;
    res.code = calc_err;
    if (calc_err == ERR_NONE) begin
      if (calc_depth == 0) res.code = ERR_UNDERFLOW;
      else res.value = calc_stack[calc_depth-1];
    end
    calc_depth = 0;
    calc_err   = ERR_NONE;
    return 1'b1;
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
  endfunction

  // Offer one item and hold it until taken
  task automatic send_item(input logic [7:0] sym, input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_symbol <= sym;
    in_last   <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Send, then queue the expected result if this item closes the expression
  task automatic apply_item(input logic [7:0] sym, input logic lst, input logic typed,
                            input eval_result_t typed_res);
    eval_result_t res;
    send_item(sym, lst);
    if (eval_symbol(sym, lst, res)) begin
      expected_q.push_back(typed ? typed_res : res);
      expr_count++;
    end
    item_count++;
  endtask

  function automatic logic [7:0] pick_operand();
    logic [7:0] s;
    case ($urandom_range(7))
      0, 1, 2: s = CH_ZERO + 8'($urandom_range(9));
      3:       s = CH_ZERO;    // zero divisors
      default: begin
        s = 8'($urandom_range(255));
        while (is_operator(s) || is_blank(s)) s = 8'($urandom_range(255));
      end
    endcase
    return s;
  endfunction

  function automatic logic [7:0] pick_operator();
    case ($urandom_range(3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      default: return CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(1) ? CH_SPACE : CH_NEWLINE;
  endfunction

  // Valid RPN; long ones push nearly everything first to overflow the stack
  task automatic build_well_formed();
    int operands;
    int pushed;
    int depth;
    int bias;
    operands = ($urandom_range(7) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
    bias     = (operands > 13) ? 15 : 3;
    pushed   = 0;
    depth    = 0;
    expr_syms.delete();
    while (pushed < operands || depth > 1) begin
      if ($urandom_range(9) == 0) expr_syms.push_back(pick_blank());
      if (pushed < operands && (depth < 2 || $urandom_range(bias) != 0)) begin
        expr_syms.push_back(pick_operand());
        pushed++;
        depth++;
      end else begin
        expr_syms.push_back(pick_operator());
        depth--;
      end
    end
  endtask

  // Random expression: mostly valid, some damaged, some pure noise
  task automatic build_expression();
    int kind;
    int len;
    kind = $urandom_range(99);
    if (kind < 70) begin
      build_well_formed();
    end else if (kind < 85) begin
      build_well_formed();
      case ($urandom_range(2))
        0:       if (expr_syms.size() > 1) void'(expr_syms.pop_back());
        1:       expr_syms.push_back(pick_operator());
        default: expr_syms.insert($urandom_range(expr_syms.size() - 1), pick_operator());
      endcase
    end else begin
      expr_syms.delete();
      len = $urandom_range(1, 12);
      repeat (len) begin
        case ($urandom_range(3))
          0:       expr_syms.push_back(pick_operator());
          1:       expr_syms.push_back(pick_blank());
          2:       expr_syms.push_back(pick_operand());
          default: expr_syms.push_back(8'($urandom_range(255)));
        endcase
      end
    end
  endtask

  // Receiver stall
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Result check against the oldest expectation
  always @(posedge clk) begin
    eval_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        note_failure($sformatf("unexpected result value=%0d code=%0d",
                               out_value, out_error_code));
      end else begin
        want = expected_q.pop_front();
        checked_count++;
        if (want.code != ERR_NONE) err_result_count++;
        if (out_value !== want.value)
          note_failure($sformatf("value: expected %0d, got %0d", want.value, out_value));
        if (out_error_code !== want.code)
          note_failure($sformatf("error_code: expected %0d, got %0d",
                                 want.code, out_error_code));
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < IDLE_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus
  initial begin
    eval_result_t typed_res;
    int           rand_start;
    int           progress;
    send_idle_pct  = 11;
    recv_stall_pct = 46;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      typed_res.value = dir_rows[i].value;
      typed_res.code  = dir_rows[i].code;
      apply_item(dir_rows[i].sym, dir_rows[i].lst, dir_rows[i].typed, typed_res);
    end

    // random expressions, idle mix changes by thirds
    rand_start = item_count;
    while (item_count - rand_start < RANDOM_ITEMS) begin
      progress = item_count - rand_start;
      if (progress < RANDOM_ITEMS / 3) begin
        send_idle_pct  = 11;
        recv_stall_pct = 46;
      end else if (progress < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct  = 46;
        recv_stall_pct = 11;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      build_expression();
      for (int k = 0; k < expr_syms.size(); k++) begin
        typed_res = '0;
        apply_item(expr_syms[k], k == expr_syms.size() - 1, 1'b0, typed_res);
      end
    end
    in_valid <= 1'b0;

    // drain
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d expression results (%0d with an error code) over %0d items.",
             checked_count, err_result_count, item_count);
    $display("Stimulus: table cases plus valid, damaged and noise RPN; %0d mismatches.",
             fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
